@@ design/ttm_pkg.sv @@
// Shared constants, register codes and table builders for the tone map pixel block.
// Depends on nothing; every other file of the block imports it.
package ttm_pkg;

	localparam int LIN_W          = 32;
	localparam int LOG_W          = 22;
	localparam int DISP_W         = 20;
	localparam int GAIN_W         = 24;
	localparam int EXPO_W         = 20;
	localparam int OFFS_W         = 18;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 24;
	localparam int LEAD_W         = 5;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int TABLE_BITS_DEF = 8;
	localparam int TABLE_BITS_MAX = 12;

	localparam logic signed [32:0] LOG2_10_Q30 = 33'sd3566893132;

	localparam logic signed [DISP_W-1:0] DISP_MAX = 20'sh7FFFF;
	localparam logic signed [DISP_W-1:0] DISP_MIN = 20'sh80000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN = 2'd0,
		CFG_EXPO = 2'd1,
		CFG_OFFS = 2'd2
	} cfg_reg_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rest;
		logic [63:0] root;
		logic [63:0] b;
		rest = v;
		root = '0;
		b = 64'h4000_0000_0000_0000;
		for (int k = 0; k < 32; k++) begin
			if (rest >= root + b) begin
				rest = rest - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// log2 of 1 + i / 2^tb, Q30
	function automatic logic [31:0] log2_entry(input int tb, input int i);
		logic [63:0] m;
		logic [63:0] r;
		m = 64'((1 << tb) + i) << (30 - tb);
		r = '0;
		if (i >= (1 << tb)) begin
			return 32'h4000_0000;
		end
		for (int k = 0; k < 30; k++) begin
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				r = r | (64'd1 << (29 - k));
			end
		end
		return r[31:0];
	endfunction

	// 2^(i / 2^tb), Q30
	function automatic logic [31:0] exp2_entry(input int tb, input int i);
		logic [63:0] roots [TABLE_BITS_MAX+1];
		logic [63:0] p;
		roots[0] = 64'h8000_0000;
		p = 64'h4000_0000;
		if (i >= (1 << tb)) begin
			return 32'h8000_0000;
		end
		for (int k = 1; k <= TABLE_BITS_MAX; k++) begin
			roots[k] = (k <= tb) ? isqrt64(roots[k-1] << 30) : roots[k-1];
		end
		for (int k = 1; k <= TABLE_BITS_MAX; k++) begin
			if (k <= tb && ((i >> (tb - k)) & 1) == 1) begin
				p = (p * roots[k] + 64'h2000_0000) >> 30;
			end
		end
		return p[31:0];
	endfunction

endpackage

@@ design/ttm_if.sv @@
// Channel interfaces of the tone map pixel block: pixel items, result items, register writes.
// Depends on ttm_pkg for field widths.
interface ttm_pix_if import ttm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    op;
	logic [LIN_W-1:0]        lum_linear;
	logic signed [LOG_W-1:0] lum_log10;

	modport source(output valid, op, lum_linear, lum_log10, input ready);
	modport sink(input valid, op, lum_linear, lum_log10, output ready);
endinterface

interface ttm_res_if import ttm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DISP_W-1:0] display_lum;
	logic                     saturated;

	modport source(output valid, display_lum, saturated, input ready);
	modport sink(input valid, display_lum, saturated, output ready);
endinterface

interface ttm_cfg_if import ttm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ design/tumblin_tone_map_pixel.sv @@
// Tone map pixel block: a * lw^b + c computed in the log2 domain, saturated to Q3.F.
// Depends on ttm_pkg and the channel interfaces in ttm_if.sv.
//
// Channels: pix carries one world luminance per item (op picks the linear Q16.F field
// or the log10 Q5.F field), res carries the mapped display luminance and a clip flag,
// cfg writes log2(a), b and c by register index; cfg is always ready and index three
// is dropped.
// Pipeline: thirteen register stages from pixel accept to result valid, one per step
// (leading-one search, normalize, log2 table, interpolate in two steps, round, multiply
// by b, add log2(a), exp2 table, interpolate in two steps, shift, add c and clip).
// Throughput: one item per cycle while res takes results; both lookup tables are
// constant logic read in their own stage.
// Reset: clears every stage valid bit and loads the register reset values
// (log2(a) = 0, b = 1.0, c = 0).
// Stall: when res is not taken, the result holds and each stage holds only while the
// one after it is full, so bubbles close up and pix.ready drops only once all
// thirteen stages hold items.
module tumblin_tone_map_pixel import ttm_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int TABLE_BITS = TABLE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ttm_pix_if.sink   pix,
	ttm_res_if.source res,
	ttm_cfg_if.sink   cfg
);

	localparam int NS    = 13;
	localparam int TBL_N = (1 << TABLE_BITS) + 1;
	localparam int RW    = 31 - TABLE_BITS;
	localparam int L2W   = (FRAC_BITS + 7 > 25) ? FRAC_BITS + 7 : 25;
	localparam int PW    = L2W + EXPO_W;
	localparam int YW    = ((PW - FRAC_BITS > 24) ? PW - FRAC_BITS : 24) + 1;
	localparam int NW    = YW - FRAC_BITS;
	localparam int CW    = NW + 8;

	localparam logic signed [CW-1:0] N_BIG  = CW'(20 - FRAC_BITS);
	localparam logic signed [CW-1:0] N_TINY = CW'(-10 - FRAC_BITS);
	localparam logic signed [CW-1:0] N_SH   = CW'(29 - FRAC_BITS);
	localparam logic [32:0]          E_MAX  = 33'(1 << 20);

	logic [31:0] log2_rom [TBL_N];
	logic [31:0] exp2_rom [TBL_N];

	for (genvar g = 0; g < TBL_N; g++) begin : g_rom
		assign log2_rom[g] = log2_entry(TABLE_BITS, g);
		assign exp2_rom[g] = exp2_entry(TABLE_BITS, g);
	end

	// register file
	logic signed [GAIN_W-1:0] gain_q;
	logic signed [EXPO_W-1:0] expo_q;
	logic signed [OFFS_W-1:0] offset_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= '0;
			expo_q   <= EXPO_W'(1 << FRAC_BITS);
			offset_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_GAIN: gain_q   <= cfg.data[GAIN_W-1:0];
				CFG_EXPO: expo_q   <= cfg.data[EXPO_W-1:0];
				CFG_OFFS: offset_q <= cfg.data[OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage valids and enables
	logic [NS:1]   vld_q;
	logic [NS+1:1] en_c;

	assign en_c[NS+1] = res.ready;
	for (genvar k = 1; k <= NS; k++) begin : g_en
		assign en_c[k] = !vld_q[k] || en_c[k+1];
	end

	assign pix.ready = en_c[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en_c[1]) begin
				vld_q[1] <= pix.valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en_c[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: leading one, log10 scale
	logic [LEAD_W-1:0]         lead_c;
	logic signed [LOG_W+32:0]  lprod_c;
	logic                      op_s1, zero_s1;
	logic [LIN_W-1:0]          x_s1;
	logic [LEAD_W-1:0]         p_s1;
	logic signed [LOG_W+32:0]  lprod_s1;

	always_comb begin
		lead_c = '0;
		for (int i = 0; i < LIN_W; i++) begin
			if (pix.lum_linear[i]) begin
				lead_c = LEAD_W'(i);
			end
		end
	end

	assign lprod_c = pix.lum_log10 * LOG2_10_Q30;

	always_ff @(posedge clk) begin
		if (en_c[1]) begin
			op_s1    <= pix.op;
			x_s1     <= pix.lum_linear;
			zero_s1  <= !pix.op && (pix.lum_linear == '0);
			p_s1     <= lead_c;
			lprod_s1 <= lprod_c;
		end
	end

	// stage 2: normalize, round log10 path
	logic [LIN_W-1:0]       norm_c;
	logic signed [63:0]     lsum_c;
	logic                   op_s2, zero_s2;
	logic [LEAD_W-1:0]      p_s2;
	logic [TABLE_BITS-1:0]  lidx_s2;
	logic [RW-1:0]          lrem_s2;
	logic signed [L2W-1:0]  l2log_s2;

	assign norm_c = x_s1 << (LEAD_W'(LIN_W - 1) - p_s1);
	assign lsum_c = 64'(lprod_s1) + 64'sd536870912;

	always_ff @(posedge clk) begin
		if (en_c[2]) begin
			op_s2    <= op_s1;
			zero_s2  <= zero_s1;
			p_s2     <= p_s1;
			lidx_s2  <= norm_c[30 -: TABLE_BITS];
			lrem_s2  <= norm_c[RW-1:0];
			l2log_s2 <= lsum_c[30 +: L2W];
		end
	end

	// stage 3: log2 table
	logic [TABLE_BITS:0]    lidx0_c, lidx1_c;
	logic                   op_s3, zero_s3;
	logic [LEAD_W-1:0]      p_s3;
	logic [RW-1:0]          lrem_s3;
	logic signed [L2W-1:0]  l2log_s3;
	logic [31:0]            lt0_s3, lt1_s3;

	assign lidx0_c = {1'b0, lidx_s2};
	assign lidx1_c = lidx0_c + (TABLE_BITS+1)'(1);

	always_ff @(posedge clk) begin
		if (en_c[3]) begin
			op_s3    <= op_s2;
			zero_s3  <= zero_s2;
			p_s3     <= p_s2;
			lrem_s3  <= lrem_s2;
			l2log_s3 <= l2log_s2;
			lt0_s3   <= log2_rom[lidx0_c];
			lt1_s3   <= log2_rom[lidx1_c];
		end
	end

	// stage 4: slope times remainder
	logic [31:0]            ldiff_c;
	logic [31+RW:0]         lmul_c;
	logic                   op_s4, zero_s4;
	logic [LEAD_W-1:0]      p_s4;
	logic signed [L2W-1:0]  l2log_s4;
	logic [31:0]            lt0_s4;
	logic [31+RW:0]         lmul_s4;

	assign ldiff_c = lt1_s3 - lt0_s3;
	assign lmul_c  = ldiff_c * lrem_s3;

	always_ff @(posedge clk) begin
		if (en_c[4]) begin
			op_s4    <= op_s3;
			zero_s4  <= zero_s3;
			p_s4     <= p_s3;
			l2log_s4 <= l2log_s3;
			lt0_s4   <= lt0_s3;
			lmul_s4  <= lmul_c;
		end
	end

	// stage 5: interpolated log2 fraction
	logic                   op_s5, zero_s5;
	logic [LEAD_W-1:0]      p_s5;
	logic signed [L2W-1:0]  l2log_s5;
	logic [31:0]            lf30_s5;

	always_ff @(posedge clk) begin
		if (en_c[5]) begin
			op_s5    <= op_s4;
			zero_s5  <= zero_s4;
			p_s5     <= p_s4;
			l2log_s5 <= l2log_s4;
			lf30_s5  <= lt0_s4 + 32'(lmul_s4 >> RW);
		end
	end

	// stage 6: round fraction, add exponent, pick path
	logic [31:0]            lfr_c;
	logic [FRAC_BITS:0]     lf_c;
	logic signed [L2W-1:0]  pm_c, l2lin_c;
	logic                   zero_s6;
	logic signed [L2W-1:0]  l2_s6;

	assign lfr_c   = lf30_s5 + 32'(1 << (29 - FRAC_BITS));
	assign lf_c    = lfr_c[30 -: (FRAC_BITS + 1)];
	assign pm_c    = L2W'($signed({1'b0, p_s5})) - L2W'(FRAC_BITS);
	assign l2lin_c = (pm_c <<< FRAC_BITS) + L2W'(lf_c);

	always_ff @(posedge clk) begin
		if (en_c[6]) begin
			zero_s6 <= zero_s5;
			l2_s6   <= op_s5 ? l2log_s5 : l2lin_c;
		end
	end

	// stage 7: times b
	logic signed [PW-1:0] yprod_c;
	logic                 zero_s7;
	logic signed [PW-1:0] yprod_s7;

	assign yprod_c = l2_s6 * expo_q;

	always_ff @(posedge clk) begin
		if (en_c[7]) begin
			zero_s7  <= zero_s6;
			yprod_s7 <= yprod_c;
		end
	end

	// stage 8: round, add log2(a)
	logic signed [PW-1:0] ysum_c;
	logic signed [YW-1:0] y_c;
	logic                 zero_s8;
	logic signed [YW-1:0] y_s8;

	assign ysum_c = yprod_s7 + PW'(1 << (FRAC_BITS - 1));
	assign y_c    = YW'($signed(ysum_c[PW-1:FRAC_BITS])) + YW'(gain_q);

	always_ff @(posedge clk) begin
		if (en_c[8]) begin
			zero_s8 <= zero_s7;
			y_s8    <= y_c;
		end
	end

	// stage 9: split integer and fraction, exp2 table
	logic signed [NW-1:0]  n_c;
	logic signed [CW-1:0]  nx_c, shx_c;
	logic [30:0]           ef31_c;
	logic [TABLE_BITS:0]   eidx0_c, eidx1_c;
	logic                  zero_s9, big_s9, tiny_s9;
	logic [5:0]            shm1_s9;
	logic [RW-1:0]         erem_s9;
	logic [31:0]           et0_s9, et1_s9;

	assign n_c     = y_s8[YW-1:FRAC_BITS];
	assign nx_c    = CW'(n_c);
	assign shx_c   = N_SH - nx_c;
	assign ef31_c  = {y_s8[FRAC_BITS-1:0], {(31 - FRAC_BITS){1'b0}}};
	assign eidx0_c = {1'b0, ef31_c[30 -: TABLE_BITS]};
	assign eidx1_c = eidx0_c + (TABLE_BITS+1)'(1);

	always_ff @(posedge clk) begin
		if (en_c[9]) begin
			zero_s9 <= zero_s8;
			big_s9  <= nx_c >= N_BIG;
			tiny_s9 <= nx_c < N_TINY;
			shm1_s9 <= shx_c[5:0];
			erem_s9 <= ef31_c[RW-1:0];
			et0_s9  <= exp2_rom[eidx0_c];
			et1_s9  <= exp2_rom[eidx1_c];
		end
	end

	// stage 10: slope times remainder
	logic [31:0]    ediff_c;
	logic [31+RW:0] emul_c;
	logic           zero_s10, big_s10, tiny_s10;
	logic [5:0]     shm1_s10;
	logic [31:0]    et0_s10;
	logic [31+RW:0] emul_s10;

	assign ediff_c = et1_s9 - et0_s9;
	assign emul_c  = ediff_c * erem_s9;

	always_ff @(posedge clk) begin
		if (en_c[10]) begin
			zero_s10 <= zero_s9;
			big_s10  <= big_s9;
			tiny_s10 <= tiny_s9;
			shm1_s10 <= shm1_s9;
			et0_s10  <= et0_s9;
			emul_s10 <= emul_c;
		end
	end

	// stage 11: interpolated power of two
	logic        zero_s11, big_s11, tiny_s11;
	logic [5:0]  shm1_s11;
	logic [32:0] t_s11;

	always_ff @(posedge clk) begin
		if (en_c[11]) begin
			zero_s11 <= zero_s10;
			big_s11  <= big_s10;
			tiny_s11 <= tiny_s10;
			shm1_s11 <= shm1_s10;
			t_s11    <= 33'(et0_s10) + 33'(emul_s10 >> RW);
		end
	end

	// stage 12: scale down with rounding, clamp
	logic [32:0] q_c;
	logic [33:0] qr_c;
	logic [32:0] er_c;
	logic [20:0] e_c;
	logic [20:0] e_s12;

	assign q_c  = t_s11 >> shm1_s11;
	assign qr_c = 34'(q_c) + 34'd1;
	assign er_c = qr_c[33:1];

	always_comb begin
		if (zero_s11 || (!big_s11 && tiny_s11)) begin
			e_c = '0;
		end else if (big_s11 || er_c > E_MAX) begin
			e_c = 21'(E_MAX);
		end else begin
			e_c = er_c[20:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_c[12]) begin
			e_s12 <= e_c;
		end
	end

	// stage 13: add c, clip
	logic signed [DISP_W+1:0] sum_c;
	logic signed [DISP_W-1:0] disp_s13;
	logic                     sat_s13;

	assign sum_c = $signed({1'b0, e_s12}) + (DISP_W+2)'(offset_q);

	always_ff @(posedge clk) begin
		if (en_c[13]) begin
			if (sum_c > (DISP_W+2)'(DISP_MAX)) begin
				disp_s13 <= DISP_MAX;
				sat_s13  <= 1'b1;
			end else if (sum_c < (DISP_W+2)'(DISP_MIN)) begin
				disp_s13 <= DISP_MIN;
				sat_s13  <= 1'b1;
			end else begin
				disp_s13 <= sum_c[DISP_W-1:0];
				sat_s13  <= 1'b0;
			end
		end
	end

	assign res.valid       = vld_q[NS];
	assign res.display_lum = disp_s13;
	assign res.saturated   = sat_s13;

endmodule

@@ design/ttm_checker.sv @@
// Port-level checks for the tone map pixel block, bound to its top level.
// Depends on ttm_pkg and tumblin_tone_map_pixel.
module ttm_checker import ttm_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     pix_ready,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic signed [DISP_W-1:0] res_display,
	input logic                     res_saturated
);

	a_idle_in_reset: assert property (@(posedge clk) !arst_n |=> !res_valid)
		else $error("result valid while in reset");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_display) && $stable(res_saturated))
		else $error("stalled result item changed");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_saturated |-> res_display == DISP_MAX || res_display == DISP_MIN)
		else $error("clip flag set on an unclipped value");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid || res_ready |-> pix_ready)
		else $error("pixel input stalled while the result side moves");

endmodule

bind tumblin_tone_map_pixel ttm_checker u_ttm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pix_ready    (pix.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_display  (res.display_lum),
	.res_saturated(res.saturated)
);
